// ===== src/bsfr_pkg.sv =====
// Package for the byte-stuffed frame receiver.
// Holds the phase type, the register map, the configuration and result structs.
// No dependencies; every other file imports it.
package bsfr_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_OP   = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    // Configuration register indexes.
    localparam logic [7:0] REG_MARKER      = 8'd0;
    localparam logic [7:0] REG_ESCAPE      = 8'd1;
    localparam logic [7:0] REG_ESC_MARKER  = 8'd2;
    localparam logic [7:0] REG_ESC_ESCAPE  = 8'd3;

    localparam logic [7:0] MARKER_RESET     = 8'd192;
    localparam logic [7:0] ESCAPE_RESET     = 8'd219;
    localparam logic [7:0] ESC_MARKER_RESET = 8'd220;
    localparam logic [7:0] ESC_ESCAPE_RESET = 8'd221;

    // Length byte and opcode byte precede the payload.
    localparam logic [8:0] HDR_BYTES = 9'd2;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic [7:0] marker_value;
        logic [7:0] escape_value;
        logic [7:0] escaped_marker_code;
        logic [7:0] escaped_escape_code;
    } cfg_t;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] frame_length;
        logic [7:0] frame_opcode;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_done;
        logic       too_short;
    } result_t;

endpackage

// ===== src/bsfr_core.sv =====
// Unstuffing and frame parsing state for the byte-stuffed frame receiver.
// Consumes one byte per step and produces at most one result combinationally.
// Depends on bsfr_pkg.
module bsfr_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  bsfr_pkg::cfg_t    cfg,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output bsfr_pkg::result_t res
);
    import bsfr_pkg::*;

    phase_t     phase_reg,   phase_next;
    logic       esc_reg,     esc_next;
    logic [7:0] length_reg,  length_next;
    logic [7:0] opcode_reg,  opcode_next;
    logic [7:0] count_reg,   count_next;

    logic       is_marker;
    logic       starts_escape;
    logic       data_ok;
    logic [7:0] decoded;
    logic       hdr_done;
    logic       data_done;

    assign is_marker     = (rx_byte == cfg.marker_value);
    assign starts_escape = !esc_reg && (rx_byte == cfg.escape_value);
    assign data_ok       = !is_marker && !starts_escape;

    always_comb begin
        if (!esc_reg) begin
            decoded = rx_byte;
        end else if (rx_byte == cfg.escaped_escape_code) begin
            decoded = cfg.escape_value;
        end else if (rx_byte == cfg.escaped_marker_code) begin
            decoded = cfg.marker_value;
        end else begin
            decoded = rx_byte;
        end
    end

    // The header reports the count before any payload; a payload result
    // reports completion with the count already advanced past this byte.
    assign hdr_done  = ({1'b0, count_reg} + HDR_BYTES) >= {1'b0, length_reg};
    assign data_done = ({1'b0, count_reg} + HDR_BYTES + 9'd1) >= {1'b0, length_reg};

    // Next state.
    always_comb begin
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        length_next = length_reg;
        opcode_next = opcode_reg;
        count_next  = count_reg;
        if (step) begin
            if (is_marker) begin
                phase_next = PH_LEN;
                count_next = 8'd0;
                esc_next   = 1'b0;
            end else if (starts_escape) begin
                esc_next = 1'b1;
            end else begin
                esc_next = 1'b0;
                unique case (phase_reg)
                    PH_LEN: begin
                        length_next = decoded;
                        phase_next  = PH_OP;
                    end
                    PH_OP: begin
                        opcode_next = decoded;
                        phase_next  = hdr_done ? PH_IDLE : PH_DATA;
                    end
                    PH_DATA: begin
                        count_next = count_reg + 8'd1;
                        if (data_done) begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Result.
    always_comb begin
        res_valid = step && data_ok && (phase_reg == PH_OP || phase_reg == PH_DATA);
        res.frame_length = length_reg;
        res.too_short    = (length_reg < HDR_BYTES[7:0]);
        unique case (phase_reg)
            PH_DATA: begin
                res.item_kind     = KIND_PAYLOAD;
                res.frame_opcode  = opcode_reg;
                res.payload_byte  = decoded;
                res.payload_index = count_reg;
                res.frame_done    = data_done;
            end
            default: begin
                res.item_kind     = KIND_HEADER;
                res.frame_opcode  = decoded;
                res.payload_byte  = 8'd0;
                res.payload_index = 8'd0;
                res.frame_done    = hdr_done;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            esc_reg    <= 1'b0;
            length_reg <= 8'd0;
            opcode_reg <= 8'd0;
            count_reg  <= 8'd0;
        end else begin
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            length_reg <= length_next;
            opcode_reg <= opcode_next;
            count_reg  <= count_next;
        end
    end

    a_marker_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && is_marker |=> phase_reg == PH_LEN && count_reg == 8'd0 && !esc_reg)
        else $error("marker did not restart the frame");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.frame_done |=> phase_reg == PH_IDLE)
        else $error("frame completed but parser did not return to idle");

    a_payload_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> ({1'b0, count_reg} + HDR_BYTES) < {1'b0, length_reg})
        else $error("payload count ran past the frame length");

    a_short_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.too_short |-> res.frame_done)
        else $error("short frame not flagged as done");

endmodule

// ===== src/bsfr_out_reg.sv =====
// Result register of the byte-stuffed frame receiver.
// Holds one result until the downstream side takes it. Depends on bsfr_pkg.
module bsfr_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  bsfr_pkg::result_t load_data,
    input  logic              m_ready,
    output logic              m_valid,
    output bsfr_pkg::result_t m_data
);
    import bsfr_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== src/byte_stuffed_frame_receiver.sv =====
// Top level of the byte-stuffed frame receiver.
// Holds the configuration registers and the input register; depends on bsfr_pkg,
// bsfr_core and bsfr_out_reg.
//
// Usage:
//   Raw line bytes enter on s_rx_byte with s_valid/s_ready. Each request is
//   unstuffed and parsed; a frame yields a header result (item_kind 0) when its
//   opcode arrives and one payload result (item_kind 1) per payload byte, on
//   the m_ channel with m_valid/m_ready. Marker, escape and length bytes, and
//   bytes outside a frame, yield no result.
//   Path: an accepted byte waits in the input register, is parsed when the
//   result register is free or being emptied, and its result is registered there.
//   Throughput: one byte per cycle while the output does not stall, set by the
//   single parse step between the input register and the result register.
//   Stalls: when m_ready is low with a result pending, the parser stops and the
//   input register holds one more byte; s_ready then drops.
//   Reset (aresetn low, synchronous): the parser waits for a marker, both
//   registers empty, and the configuration returns to marker 192, escape 219,
//   escaped marker code 220 and escaped escape code 221. Configuration writes
//   (cfg_wr_en, cfg_index, cfg_wdata) take effect at once and belong in idle
//   periods; indexes beyond the fourth register are ignored.
module byte_stuffed_frame_receiver (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_item_kind,
    output logic [7:0] m_frame_length,
    output logic [7:0] m_frame_opcode,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_payload_index,
    output logic       m_frame_done,
    output logic       m_too_short
);
    import bsfr_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       step;
    logic       res_valid;
    result_t    res;
    result_t    out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.marker_value        <= MARKER_RESET;
            cfg_reg.escape_value        <= ESCAPE_RESET;
            cfg_reg.escaped_marker_code <= ESC_MARKER_RESET;
            cfg_reg.escaped_escape_code <= ESC_ESCAPE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MARKER:     cfg_reg.marker_value        <= cfg_wdata;
                REG_ESCAPE:     cfg_reg.escape_value        <= cfg_wdata;
                REG_ESC_MARKER: cfg_reg.escaped_marker_code <= cfg_wdata;
                REG_ESC_ESCAPE: cfg_reg.escaped_escape_code <= cfg_wdata;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // The parser advances whenever a byte is held and the result register
    // is free or being emptied this cycle.
    assign step    = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    bsfr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    bsfr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (out_data)
    );

    assign m_item_kind     = out_data.item_kind;
    assign m_frame_length  = out_data.frame_length;
    assign m_frame_opcode  = out_data.frame_opcode;
    assign m_payload_byte  = out_data.payload_byte;
    assign m_payload_index = out_data.payload_index;
    assign m_frame_done    = out_data.frame_done;
    assign m_too_short     = out_data.too_short;

endmodule
